### src/kcnt_pkg.sv
// Package of the canonical k-mer counter: operation codes, back-end command
// codes, the command and configuration structs, and the sizing constants.
// No dependencies.
package kcnt_pkg;

  // Default sizing of the block.
  localparam int unsigned DefMaxK       = 8;
  localparam int unsigned DefCountWidth = 32;

  // Widest k-mer code that any legal MAX_K can give (MAX_K is at most 16).
  localparam int unsigned AddrMaxW = 32;

  // Entries in the queue between the front and the back.
  localparam int unsigned QueueDepth = 4;

  // Fixed widths of the item fields.
  localparam int unsigned OpW       = 2;
  localparam int unsigned CharW     = 8;
  localparam int unsigned ReadIdxW  = 16;
  localparam int unsigned OutW      = 32;
  localparam int unsigned KLenW     = 4;

  // Register reset values.
  localparam logic [KLenW-1:0] KLengthReset   = 4'd3;
  localparam logic             CanonicalReset = 1'b1;

  // ASCII codes of the four bases.
  localparam logic [CharW-1:0] CharA = 8'h41;
  localparam logic [CharW-1:0] CharC = 8'h43;
  localparam logic [CharW-1:0] CharG = 8'h47;
  localparam logic [CharW-1:0] CharT = 8'h54;

  typedef enum logic [OpW-1:0] {
    OP_FEED  = 2'd0,
    OP_END   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_INC   = 2'd0,
    CMD_DROP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_K_LENGTH  = 1'b0,
    REG_CANONICAL = 1'b1
  } reg_e;

  typedef struct packed {
    cmd_e                kind;
    logic [AddrMaxW-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [KLenW-1:0] k_length;
    logic             canonical_mode;
  } cfg_t;

endpackage

### src/kcnt_if.sv
// Stream interfaces of the canonical k-mer counter: the item channel and the
// result channel, each with valid/ready. Depends on kcnt_pkg.
interface kcnt_in_if
  import kcnt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OpW-1:0]      op;
  logic [CharW-1:0]    base_char;
  logic [ReadIdxW-1:0] read_index;

  modport source (output valid, output op, output base_char, output read_index,
                  input ready);
  modport sink   (input valid, input op, input base_char, input read_index,
                  output ready);
endinterface

interface kcnt_out_if
  import kcnt_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [OutW-1:0] kmer_count;
  logic [OutW-1:0] dropped_windows;

  modport source (output valid, output kmer_count, output dropped_windows,
                  input ready);
  modport sink   (input valid, input kmer_count, input dropped_windows,
                  output ready);
endinterface

### src/canonical_kmer_counter_top.sv
// Top level of the canonical k-mer counter: configuration registers behind an
// APB-style port, and the front, queue and back. Uses kcnt_pkg and kcnt_if.
//
// The counter takes one operation per transfer on the item channel: feed a
// base character, end the contig, read one count, or clear the histogram.
// The front accepts an item in every cycle in which the four-entry command
// queue has room; ending a contig and feeding a base that completes no window
// leave nothing in the queue. The back sets the pace: a counted window is a
// read-modify-write of the count memory, a dropped window only bumps the
// dropped-window counter, and a read waits for the previous result to be
// taken, since a single result register holds it. After reset and after
// every clear, the back walks all 4^MAX_K entries of the count memory
// (65536 at the default MAX_K of 8) once to zero them, one entry per cycle;
// during that walk the front still accepts items until the queue fills. The
// registers are k_length at byte address 0 and canonical_mode at byte address
// 4; the k and the mode are applied when an item enters the front, so they
// must be written by the user only while idle; the block does not enforce it.
module canonical_kmer_counter_top
  import kcnt_pkg::*;
#(
  parameter int unsigned MAX_K       = DefMaxK,
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kcnt_in_if.sink     in_i,
  kcnt_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_q;
  logic cfg_we;
  reg_e reg_sel;
  logic q_push, q_full, q_pop, q_head_valid;
  cmd_t q_push_cmd, q_head_cmd;

  // Register index is the word address; the byte offset within a word is
  // ignored.
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k_length       <= KLengthReset;
      cfg_q.canonical_mode <= CanonicalReset;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_K_LENGTH:  cfg_q.k_length       <= pwdata[KLenW-1:0];
        REG_CANONICAL: cfg_q.canonical_mode <= pwdata[0];
        default:       cfg_q                <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_K_LENGTH:  prdata = 32'(cfg_q.k_length);
      REG_CANONICAL: prdata = 32'(cfg_q.canonical_mode);
      default:       prdata = '0;
    endcase
  end

  // The front classifies each item against the current k and mode.
  kcnt_front #(
    .MAX_K (MAX_K)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_cmd_o (q_push_cmd)
  );

  // The queue lets the front keep taking items while the back is busy with a
  // clearing walk or a read-modify-write, and lets the back drain while the
  // item channel is idle.
  kcnt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_cmd_i   (q_push_cmd),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_cmd_o   (q_head_cmd)
  );

  kcnt_back #(
    .MAX_K       (MAX_K),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_cmd_i   (q_head_cmd),
    .pop_o        (q_pop),
    .out_o        (out_o)
  );

endmodule

### src/kcnt_front.sv
// Front end of the k-mer counter: accepts items, keeps the rolling codes and
// run counters; turns windows, reads and clears into commands. Uses kcnt_pkg.
module kcnt_front
  import kcnt_pkg::*;
#(
  parameter int unsigned MAX_K = DefMaxK
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  kcnt_in_if.sink    in_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       push_cmd_o
);

  localparam int unsigned CodeW = 2 * MAX_K;
  localparam int unsigned KW    = $clog2(MAX_K + 1);
  localparam int unsigned ShW   = $clog2(CodeW + 1);

  logic [CodeW-1:0] fwd_q, fwd_d, rev_q, rev_d;
  logic [KW-1:0]    bases_q, bases_d, run_q, run_d;
  logic [KW-1:0]    eff_k;
  logic [CodeW-1:0] mask, idx;
  logic [ShW-1:0]   mask_sh, top_sh;
  logic [1:0]       code;
  logic             ok, accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // A k of zero acts as one, a k above MAX_K as MAX_K.
  always_comb begin
    if (cfg_i.k_length == '0) begin
      eff_k = KW'(1);
    end else if (5'(cfg_i.k_length) > 5'(MAX_K)) begin
      eff_k = KW'(MAX_K);
    end else begin
      eff_k = KW'(cfg_i.k_length);
    end
  end

  always_comb begin
    ok   = 1'b1;
    code = 2'd0;
    unique case (in_i.base_char)
      CharA:   code = 2'd0;
      CharC:   code = 2'd1;
      CharG:   code = 2'd2;
      CharT:   code = 2'd3;
      default: ok = 1'b0;
    endcase
  end

  assign mask_sh = ShW'(CodeW) - ShW'({eff_k, 1'b0});
  assign top_sh  = ShW'({eff_k - KW'(1), 1'b0});
  assign mask    = {CodeW{1'b1}} >> mask_sh;

  always_comb begin
    fwd_d   = ((fwd_q << 2) | CodeW'(code)) & mask;
    rev_d   = ((rev_q & mask) >> 2) | (CodeW'(2'd3 - code) << top_sh);
    bases_d = (bases_q > eff_k) ? eff_k : bases_q;
    run_d   = (run_q > eff_k) ? eff_k : run_q;
    if (bases_d < eff_k) begin
      bases_d = bases_d + KW'(1);
    end
    if (!ok) begin
      run_d = '0;
    end else if (run_d < eff_k) begin
      run_d = run_d + KW'(1);
    end
  end

  assign idx = (cfg_i.canonical_mode && (rev_d < fwd_d)) ? rev_d : fwd_d;

  always_comb begin
    push_o          = 1'b0;
    push_cmd_o.kind = CMD_INC;
    push_cmd_o.addr = AddrMaxW'(idx);
    unique case (op_e'(in_i.op))
      OP_FEED: begin
        push_o          = accept && (bases_d == eff_k);
        push_cmd_o.kind = (run_d == eff_k) ? CMD_INC : CMD_DROP;
      end
      OP_READ: begin
        push_o          = accept;
        push_cmd_o.kind = CMD_READ;
        push_cmd_o.addr = AddrMaxW'(CodeW'(in_i.read_index));
      end
      OP_CLEAR: begin
        push_o          = accept;
        push_cmd_o.kind = CMD_CLEAR;
      end
      default: push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q   <= '0;
      rev_q   <= '0;
      bases_q <= '0;
      run_q   <= '0;
    end else if (accept) begin
      if (op_e'(in_i.op) == OP_FEED) begin
        fwd_q   <= fwd_d;
        rev_q   <= rev_d;
        bases_q <= bases_d;
        run_q   <= run_d;
      end else if (op_e'(in_i.op) == OP_END) begin
        fwd_q   <= '0;
        rev_q   <= '0;
        bases_q <= '0;
        run_q   <= '0;
      end
    end
  end

endmodule

### src/kcnt_queue.sv
// Short command queue between the front and the back of the k-mer counter.
// Uses kcnt_pkg for the command struct and the depth.
module kcnt_queue
  import kcnt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_cmd_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### src/kcnt_back.sv
// Back end of the k-mer counter: the count memory with its read-modify-write,
// the dropped-window counter, the clearing pass and the result register.
// Uses kcnt_pkg.
module kcnt_back
  import kcnt_pkg::*;
#(
  parameter int unsigned MAX_K       = DefMaxK,
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  cmd_t       head_cmd_i,
  output logic       pop_o,
  kcnt_out_if.source out_o
);

  localparam int unsigned AddrW = 2 * MAX_K;
  localparam int unsigned Depth = 1 << AddrW;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_INC   = 4'b0100,
    ST_READ  = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [COUNT_WIDTH-1:0] count_mem_q [Depth];
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [AddrW-1:0]       mem_waddr, mem_raddr;
  logic                   mem_we;
  logic [AddrW-1:0]       addr_q, addr_d;
  logic [AddrW-1:0]       clr_q, clr_d;
  logic [COUNT_WIDTH-1:0] drop_q, drop_d;
  logic                   out_valid_q, out_valid_d;
  logic [OutW-1:0]        out_count_q, out_count_d, out_drop_q, out_drop_d;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [OutW-1:0] clip(logic [COUNT_WIDTH-1:0] v);
    return (|(v >> OutW)) ? {OutW{1'b1}} : OutW'(v);
  endfunction

  assign mem_raddr = head_cmd_i.addr[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      count_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= count_mem_q[mem_raddr];
  end

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    clr_d       = clr_q;
    drop_d      = drop_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = '0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_count_d = out_count_q;
    out_drop_d  = out_drop_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AddrW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          unique case (head_cmd_i.kind)
            CMD_INC: begin
              pop_o   = 1'b1;
              addr_d  = head_cmd_i.addr[AddrW-1:0];
              state_d = ST_INC;
            end
            CMD_DROP: begin
              pop_o  = 1'b1;
              drop_d = sat_inc(drop_q);
            end
            CMD_READ: begin
              // Only one result is held; the read waits for the register to empty.
              if (!out_valid_q) begin
                pop_o   = 1'b1;
                state_d = ST_READ;
              end
            end
            CMD_CLEAR: begin
              pop_o   = 1'b1;
              drop_d  = '0;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            default: pop_o = 1'b0;
          endcase
        end
      end
      ST_INC: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = sat_inc(rdata_q);
        state_d   = ST_IDLE;
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_count_d = clip(rdata_q);
        out_drop_d  = clip(drop_q);
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    out_count_q <= out_count_d;
    out_drop_q  <= out_drop_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.kmer_count      = out_count_q;
  assign out_o.dropped_windows = out_drop_q;

endmodule

### dv/tb_canonical_kmer_counter_top.sv
// Self-checking testbench of canonical_kmer_counter_top: directed and random
// base streams, contig ends, count reads and clears under random back-pressure.
// Depends on kcnt_pkg, kcnt_if and the RTL of the counter.
module tb_canonical_kmer_counter_top;
  import kcnt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxK = DefMaxK;
  localparam int unsigned StoreMask = (32'd1 << (2 * MaxK)) - 1;
  // Idle cycles after the flushing read has returned, before the registers
  // are changed. Once that read is back, the queue and the back are empty.
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseCount = 10;
  localparam int unsigned ItemsPerPhase = 105;

  // What one read is expected to return.
  typedef struct packed {
    logic [OutW-1:0] kmer_count;
    logic [OutW-1:0] dropped;
  } tally_t;

  // Scoreboard: keeps its own copy of the registers, the rolling window and
  // the histogram, and turns every accepted read into an expected tally.
  class kmer_scoreboard;
    logic [KLenW-1:0] k_length;
    logic             canonical;
    int unsigned      fwd_code;
    int unsigned      rc_code;
    int unsigned      bases_seen;
    int unsigned      acgt_run;
    logic [OutW-1:0]  histogram [int unsigned];
    logic [OutW-1:0]  dropped_total;
    tally_t           pending_reads [$];
    logic [15:0]      last_kmer;
    int               errors;

    function new();
      k_length      = KLengthReset;
      canonical     = CanonicalReset;
      fwd_code      = 0;
      rc_code       = 0;
      bases_seen    = 0;
      acgt_run      = 0;
      dropped_total = '0;
      last_kmer     = '0;
      errors        = 0;
    endfunction

    function void set_reg(reg_e r, logic [31:0] value);
      if (r == REG_K_LENGTH) begin
        k_length = value[KLenW-1:0];
      end else begin
        canonical = value[0];
      end
    endfunction

    // A k of zero behaves as one, anything above the maximum as the maximum.
    function int unsigned window_len();
      if (k_length == 0) return 1;
      if (k_length > MaxK) return MaxK;
      return 32'(k_length);
    endfunction

    function logic [OutW-1:0] count_at(int unsigned idx);
      return histogram.exists(idx) ? histogram[idx] : '0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void feed_base(logic [CharW-1:0] ch);
      int unsigned k;
      int unsigned mask;
      int unsigned code;
      int unsigned idx;
      bit          acgt;
      k    = window_len();
      mask = (32'd1 << (2 * k)) - 1;
      acgt = 1'b1;
      case (ch)
        CharA: code = 0;
        CharC: code = 1;
        CharG: code = 2;
        CharT: code = 3;
        default: begin
          // Anything else enters the codes as A but breaks the run.
          code = 0;
          acgt = 1'b0;
        end
      endcase
      fwd_code = ((fwd_code << 2) | code) & mask;
      rc_code  = ((rc_code & mask) >> 2) | ((3 - code) << (2 * (k - 1)));
      // Counters left over from a larger k are clamped to the current one.
      if (bases_seen > k) bases_seen = k;
      if (acgt_run > k) acgt_run = k;
      if (bases_seen < k) bases_seen++;
      if (!acgt) begin
        acgt_run = 0;
      end else if (acgt_run < k) begin
        acgt_run++;
      end
      if (bases_seen == k) begin
        if (acgt_run == k) begin
          idx = fwd_code;
          if (canonical && rc_code < idx) idx = rc_code;
          idx &= StoreMask;
          last_kmer = idx[15:0];
          if (count_at(idx) != '1) histogram[idx] = count_at(idx) + 1;
        end else if (dropped_total != '1) begin
          dropped_total++;
        end
      end
    endfunction

    function void note_item(op_e op, logic [CharW-1:0] ch, logic [ReadIdxW-1:0] ri);
      tally_t t;
      case (op)
        OP_FEED: feed_base(ch);
        OP_END: begin
          fwd_code   = 0;
          rc_code    = 0;
          bases_seen = 0;
          acgt_run   = 0;
        end
        OP_READ: begin
          t.kmer_count = count_at(ri & StoreMask);
          t.dropped    = dropped_total;
          pending_reads.insert(pending_reads.size(), t);
        end
        default: begin
          // A clear leaves the window as it stands.
          histogram.delete();
          dropped_total = '0;
        end
      endcase
    endfunction

    function void check_result(logic [OutW-1:0] cnt, logic [OutW-1:0] drp);
      tally_t t;
      if (pending_reads.size() == 0) begin
        report($sformatf("%0t: result with no read outstanding: count %0d dropped %0d",
                         $realtime, cnt, drp));
        return;
      end
      t = pending_reads.pop_front();
      if (t.kmer_count !== cnt || t.dropped !== drp) begin
        report($sformatf("%0t: read mismatch: count exp %0d got %0d, dropped exp %0d got %0d",
                         $realtime, t.kmer_count, cnt, t.dropped, drp));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  // High during stretches in which neither side inserts idle cycles.
  logic        hurry;

  kcnt_in_if  in_bus ();
  kcnt_out_if out_bus ();

  kmer_scoreboard sb = new();

  canonical_kmer_counter_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run is bounded by the reset walk and three clears, each a walk over
  // 65536 entries, plus about 1100 items; the limit below is several times
  // that.
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // Monitor: every transfer on either channel is seen here at the clock edge,
  // with the values that were present before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
        sb.note_item(op_e'(in_bus.op), in_bus.base_char, in_bus.read_index);
      end
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        sb.check_result(out_bus.kmer_count, out_bus.dropped_windows);
      end
    end
  end

  // Result side: before each transfer, ready is held low for a random number
  // of cycles, counted from the previous transfer whether or not a result is
  // waiting, so stalls land on every phase of the back end.
  initial begin
    int unsigned stall;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = hurry ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_bus.valid === 1'b1 && out_bus.ready === 1'b1));
    end
  end

  // Presents one item after a random gap and returns at the edge of its
  // transfer. With no gap, valid simply stays high for the next item.
  task automatic send_item(op_e op, logic [CharW-1:0] ch, logic [ReadIdxW-1:0] ri);
    int unsigned gap;
    gap = hurry ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.base_char  <= ch;
    in_bus.read_index <= ri;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
  endtask

  task automatic feed(logic [CharW-1:0] ch);
    send_item(OP_FEED, ch, ReadIdxW'($urandom_range(0, 65535)));
  endtask

  task automatic read_at(logic [ReadIdxW-1:0] ri);
    send_item(OP_READ, CharW'($urandom_range(0, 255)), ri);
  endtask

  // Register write in a setup and an access phase; the register takes the
  // value at the edge of the access cycle.
  task automatic write_reg(reg_e r, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, value);
  endtask

  // Sends one more read and stops the item stream. Commands are carried out
  // in order, so once every read has returned, anything queued before it,
  // a clearing walk included, has completed.
  task automatic settle();
    read_at(16'd0);
    in_bus.valid <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One random item. Most items feed A, C, G or T so that full windows form;
  // a few feed arbitrary bytes, end the contig or read a count. Reads mostly
  // target the newest counted k-mer or a rank inside 4^k.
  task automatic random_item(bit clear_now);
    int unsigned       r;
    int unsigned       k;
    logic [CharW-1:0]  ch;
    logic [ReadIdxW-1:0] ri;
    ch = CharW'($urandom_range(0, 255));
    ri = ReadIdxW'($urandom_range(0, 65535));
    if (clear_now) begin
      send_item(OP_CLEAR, ch, ri);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 11) != 0) begin
          case ($urandom_range(0, 3))
            0: ch = CharA;
            1: ch = CharC;
            2: ch = CharG;
            default: ch = CharT;
          endcase
        end
        send_item(OP_FEED, ch, ri);
      end else if (r < 75) begin
        send_item(OP_END, ch, ri);
      end else begin
        k = sb.window_len();
        r = $urandom_range(0, 9);
        if (r < 4) begin
          ri = sb.last_kmer;
        end else if (r < 8) begin
          ri = ReadIdxW'($urandom_range(0, (32'd1 << (2 * k)) - 1));
        end
        send_item(OP_READ, ch, ri);
      end
    end
  endtask

  initial begin
    logic [KLenW-1:0] phase_k [PhaseCount];
    bit               phase_canon [PhaseCount];
    int unsigned      clear_slot;
    phase_k     = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd4, 4'd7, 4'd6, 4'd3};
    phase_canon = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    in_bus.valid      <= 1'b0;
    in_bus.op         <= OP_FEED;
    in_bus.base_char  <= '0;
    in_bus.read_index <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    hurry             <= 1'b0;
    rst_ni            <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset settings, k of three in canonical mode.
    // ACG and CGT are reverse complements of each other, so both windows
    // land on the same rank.
    feed(CharA);
    feed(CharC);
    feed(CharG);
    feed(CharT);
    read_at(16'd6);
    // Lowercase, other letters and the byte extremes are all invalid; every
    // window covering one of them is dropped until three good bases follow.
    feed(8'h61);
    feed(8'h4E);
    feed(8'h00);
    feed(8'hFF);
    feed(CharT);
    feed(CharT);
    feed(CharT);
    send_item(OP_END, 8'hFF, 16'hFFFF);
    // A contig shorter than k gives no window at all.
    feed(CharG);
    feed(CharG);
    send_item(OP_END, 8'h00, 16'h0000);
    read_at(16'd0);
    // Rank far beyond 4^k, with every index bit set.
    read_at(16'hFFFF);
    send_item(OP_CLEAR, CharA, 16'd6);
    read_at(16'd6);
    feed(CharC);
    read_at(16'd0);

    // Random part: each phase runs at its own register settings, with the
    // contig left open across the change so that k also changes mid-contig.
    // Two of the phases contain a clear at a random point.
    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      write_reg(REG_K_LENGTH, {28'd0, phase_k[p]});
      write_reg(REG_CANONICAL, {31'd0, phase_canon[p]});
      hurry <= (p % 3 == 2);
      clear_slot = (p == 3 || p == 6) ? $urandom_range(10, ItemsPerPhase - 10) : ItemsPerPhase;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        random_item(i == clear_slot);
      end
    end

    hurry <= 1'b0;
    settle();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
